@@ src/weighted_line_fit_unit_defines.svh @@
// Assertion macros shared by the weighted line fit RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef WEIGHTED_LINE_FIT_UNIT_DEFINES_SVH
`define WEIGHTED_LINE_FIT_UNIT_DEFINES_SVH

// The consequence must hold in the same cycle as the condition.
`define WLF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the condition.
`define WLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/wlf_pkg.sv @@
// Shared constants and unit request/response types for the weighted line fit.
// Used by every module of the block but wlf_ram; depends on nothing.
package wlf_pkg;

  // Point store geometry.
  localparam int MAX_POINTS = 4096;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
  localparam int RAM_W      = 80;

  // Divider control widths: up to 128 + 48 steps.
  localparam int FRAC_W = 6;
  localparam int STEP_W = 8;

  // Fit status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN   = 2'd1;
  localparam logic [1:0] ST_ZERO_SIGMA = 2'd2;
  localparam logic [1:0] ST_OVERFLOW   = 2'd3;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [127:0]      num;
    logic [127:0]      den;
    logic [FRAC_W-1:0] frac;
    logic [63:0]       cap;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] val;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage

@@ src/weighted_line_fit_unit.sv @@
// Weighted least-squares straight-line fit. Each point transaction, while the store
// has room, is written to a 4096-entry point RAM and its weight 1/sigma^2 (a divide,
// skipped for zero sigma) and four products (a shared four-step multiplier) are
// folded into the running sums; in_ready is high only between points. The last
// point then runs the fit on the same divider, multiplier and a 32-step square root,
// followed by the chi-square walk over the points stored in the RAM. A finished
// result waits in the output register while the next data set loads. No clearing
// pass is needed after reset.
// Depends on wlf_pkg, wlf_ram, wlf_mul, wlf_div, wlf_sqrt and the defines header.
`include "weighted_line_fit_unit_defines.svh"

module weighted_line_fit_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] x_value,
  input  logic [31:0] y_value,
  input  logic [15:0] sigma_value,
  input  logic        last_point,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] intercept,
  output logic [31:0] slope,
  output logic [31:0] intercept_error,
  output logic [31:0] slope_error,
  output logic [31:0] chi_square,
  output logic [12:0] points_used,
  output logic [1:0]  fit_status
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_WDIV    = 5'd1;
  localparam logic [4:0] S_WX      = 5'd2;
  localparam logic [4:0] S_WY      = 5'd3;
  localparam logic [4:0] S_TXX     = 5'd4;
  localparam logic [4:0] S_TXY     = 5'd5;
  localparam logic [4:0] S_FIT     = 5'd6;
  localparam logic [4:0] S_PP      = 5'd7;
  localparam logic [4:0] S_QQ      = 5'd8;
  localparam logic [4:0] S_N1      = 5'd9;
  localparam logic [4:0] S_N2      = 5'd10;
  localparam logic [4:0] S_ASTART  = 5'd11;
  localparam logic [4:0] S_AWAIT   = 5'd12;
  localparam logic [4:0] S_N3      = 5'd13;
  localparam logic [4:0] S_N4      = 5'd14;
  localparam logic [4:0] S_BSTART  = 5'd15;
  localparam logic [4:0] S_BWAIT   = 5'd16;
  localparam logic [4:0] S_EADIV   = 5'd17;
  localparam logic [4:0] S_EASQ    = 5'd18;
  localparam logic [4:0] S_EBDIV   = 5'd19;
  localparam logic [4:0] S_EBSQ    = 5'd20;
  localparam logic [4:0] S_CRD     = 5'd21;
  localparam logic [4:0] S_CDATA   = 5'd22;
  localparam logic [4:0] S_CRES    = 5'd23;
  localparam logic [4:0] S_CMUL    = 5'd24;
  localparam logic [4:0] S_CDIV    = 5'd25;
  localparam logic [4:0] S_EMIT    = 5'd26;

  localparam int CW = wlf_pkg::COUNT_W;
  localparam int AW = wlf_pkg::ADDR_W;

  // Saturating signed 64-bit add.
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return s;
  endfunction

  // Magnitude of a signed 64-bit value.
  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  logic [4:0]          state;
  logic [CW-1:0]       point_count;
  logic [1:0]          error_flags;
  logic [63:0]         sum_weight;
  logic [63:0]         sum_weighted_x;
  logic [63:0]         sum_weighted_y;
  logic [63:0]         sum_weighted_xy;
  logic [63:0]         sum_weighted_xx;
  logic [31:0]         pt_x;
  logic [31:0]         pt_y;
  logic                pt_last;
  logic [63:0]         w_q;
  logic [63:0]         wx;
  logic [63:0]         wy;
  logic [63:0]         txx;
  logic [127:0]        pp;
  logic [127:0]        den_d;
  logic [127:0]        term;
  logic [127:0]        num;
  logic                num_neg;
  logic signed [31:0]  fit_a;
  logic signed [31:0]  fit_b;
  logic [31:0]         fit_ea;
  logic [31:0]         fit_eb;
  logic [31:0]         chi;
  logic [1:0]          status;
  logic [CW-1:0]       idx;
  logic signed [63:0]  bx;
  logic [63:0]         ya;
  logic [63:0]         chi_den;
  wlf_pkg::mul_req_t   mul_req;
  wlf_pkg::mul_rsp_t   mul_rsp;
  wlf_pkg::div_req_t   div_req;
  wlf_pkg::div_rsp_t   div_rsp;
  wlf_pkg::sqrt_req_t  sqrt_req;
  wlf_pkg::sqrt_rsp_t  sqrt_rsp;
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [wlf_pkg::RAM_W-1:0] ram_wdata;
  logic [wlf_pkg::RAM_W-1:0] ram_rdata;
  logic                in_acc;
  logic                full;
  logic [31:0]         sig_sq;
  logic [63:0]         tx;
  logic [63:0]         ty;
  logic [63:0]         txy;
  logic [127:0]        sprod;
  logic signed [31:0]  rd_x;
  logic [31:0]         rd_y;
  logic [15:0]         rd_sig;
  logic [63:0]         resid;
  logic [32:0]         chi_sum;
  logic                emit_go;

  // Handshake and point RAM access.
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign full      = (point_count >= CW'(wlf_pkg::MAX_POINTS));
  assign ram_we    = in_acc && !full;
  assign ram_addr  = (state == S_IDLE) ? point_count[AW-1:0] : idx[AW-1:0];
  assign ram_wdata = {x_value, y_value, sigma_value};
  assign emit_go   = (state == S_EMIT) && (!out_valid || out_ready);

  // Per-point terms and chi-square residual arithmetic.
  always_comb begin
    sig_sq  = sigma_value * sigma_value;
    tx      = {16'b0, wx[63:16]};
    ty      = {16'b0, wy[63:16]};
    if (pt_x[31]) tx = 64'd0 - tx;
    if (pt_y[31]) ty = 64'd0 - ty;
    txy     = mul_rsp.prod[95:32];
    if (pt_x[31] != pt_y[31]) txy = 64'd0 - txy;
    sprod   = 128'd0 - mul_rsp.prod;
    rd_x    = ram_rdata[79:48];
    rd_y    = ram_rdata[47:16];
    rd_sig  = ram_rdata[15:0];
    resid   = ya - bx;
    chi_sum = {1'b0, chi} + {1'b0, div_rsp.quo[31:0]};
  end

  wlf_ram #(
    .WIDTH(wlf_pkg::RAM_W),
    .DEPTH(wlf_pkg::MAX_POINTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  wlf_mul u_mul (
    .clk(clk),
    .rst(rst),
    .req(mul_req),
    .rsp(mul_rsp)
  );

  wlf_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  wlf_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .req(sqrt_req),
    .rsp(sqrt_rsp)
  );

  // Sequencer: point loading, then the fit and the chi-square walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      point_count     <= '0;
      error_flags     <= wlf_pkg::ST_OK;
      sum_weight      <= '0;
      sum_weighted_x  <= '0;
      sum_weighted_y  <= '0;
      sum_weighted_xy <= '0;
      sum_weighted_xx <= '0;
      out_valid       <= 1'b0;
      mul_req.start   <= 1'b0;
      div_req.start   <= 1'b0;
      sqrt_req.start  <= 1'b0;
    end else begin
      mul_req.start  <= 1'b0;
      div_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;
      // A taken result is dropped unless a new one replaces it this cycle.
      if (out_valid && out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            pt_x    <= x_value;
            pt_y    <= y_value;
            pt_last <= last_point;
            if (full) begin
              error_flags <= wlf_pkg::ST_OVERFLOW;
              state       <= last_point ? S_FIT : S_IDLE;
            end else begin
              point_count <= point_count + CW'(1);
              if (sigma_value == 16'd0) begin
                if (error_flags < wlf_pkg::ST_ZERO_SIGMA) begin
                  error_flags <= wlf_pkg::ST_ZERO_SIGMA;
                end
                w_q           <= '0;
                mul_req.start <= 1'b1;
                mul_req.a     <= '0;
                mul_req.b     <= mag64({{32{x_value[31]}}, x_value});
                state         <= S_WX;
              end else begin
                div_req.start <= 1'b1;
                div_req.num   <= {95'b0, 1'b1, 32'b0};
                div_req.den   <= {96'b0, sig_sq};
                div_req.frac  <= '0;
                div_req.cap   <= '1;
                state         <= S_WDIV;
              end
            end
          end
        end
        S_WDIV: begin
          if (div_rsp.done) begin
            w_q           <= div_rsp.quo;
            mul_req.start <= 1'b1;
            mul_req.a     <= div_rsp.quo;
            mul_req.b     <= mag64({{32{pt_x[31]}}, pt_x});
            state         <= S_WX;
          end
        end
        S_WX: begin
          if (mul_rsp.done) begin
            wx            <= mul_rsp.prod[63:0];
            mul_req.start <= 1'b1;
            mul_req.a     <= w_q;
            mul_req.b     <= mag64({{32{pt_y[31]}}, pt_y});
            state         <= S_WY;
          end
        end
        S_WY: begin
          if (mul_rsp.done) begin
            wy            <= mul_rsp.prod[63:0];
            mul_req.start <= 1'b1;
            mul_req.a     <= wx;
            mul_req.b     <= mag64({{32{pt_x[31]}}, pt_x});
            state         <= S_TXX;
          end
        end
        S_TXX: begin
          if (mul_rsp.done) begin
            txx           <= mul_rsp.prod[95:32];
            mul_req.start <= 1'b1;
            mul_req.a     <= wx;
            mul_req.b     <= mag64({{32{pt_y[31]}}, pt_y});
            state         <= S_TXY;
          end
        end
        S_TXY: begin
          if (mul_rsp.done) begin
            sum_weight      <= sum_weight + w_q;
            sum_weighted_x  <= sat_add(sum_weighted_x, tx);
            sum_weighted_y  <= sat_add(sum_weighted_y, ty);
            sum_weighted_xx <= sat_add(sum_weighted_xx, txx);
            sum_weighted_xy <= sat_add(sum_weighted_xy, txy);
            state           <= pt_last ? S_FIT : S_IDLE;
          end
        end
        S_FIT: begin
          if (error_flags != wlf_pkg::ST_OK) begin
            status <= error_flags;
            state  <= S_EMIT;
          end else if (point_count < CW'(2)) begin
            status <= wlf_pkg::ST_ZERO_DEN;
            state  <= S_EMIT;
          end else begin
            status        <= wlf_pkg::ST_OK;
            mul_req.start <= 1'b1;
            mul_req.a     <= sum_weight;
            mul_req.b     <= sum_weighted_xx;
            state         <= S_PP;
          end
        end
        S_PP: begin
          if (mul_rsp.done) begin
            pp            <= mul_rsp.prod;
            mul_req.start <= 1'b1;
            mul_req.a     <= mag64(sum_weighted_x);
            mul_req.b     <= mag64(sum_weighted_x);
            state         <= S_QQ;
          end
        end
        S_QQ: begin
          if (mul_rsp.done) begin
            if (pp <= mul_rsp.prod) begin
              status <= wlf_pkg::ST_ZERO_DEN;
              state  <= S_EMIT;
            end else begin
              den_d         <= pp - mul_rsp.prod;
              mul_req.start <= 1'b1;
              mul_req.a     <= mag64(sum_weighted_xx);
              mul_req.b     <= mag64(sum_weighted_y);
              state         <= S_N1;
            end
          end
        end
        S_N1: begin
          if (mul_rsp.done) begin
            term          <= (sum_weighted_xx[63] ^ sum_weighted_y[63]) ? sprod : mul_rsp.prod;
            mul_req.start <= 1'b1;
            mul_req.a     <= mag64(sum_weighted_x);
            mul_req.b     <= mag64(sum_weighted_xy);
            state         <= S_N2;
          end
        end
        S_N2: begin
          if (mul_rsp.done) begin
            num   <= (sum_weighted_x[63] ^ sum_weighted_xy[63]) ? (term + mul_rsp.prod)
                                                                : (term - mul_rsp.prod);
            state <= S_ASTART;
          end
        end
        S_ASTART, S_BSTART: begin
          num_neg       <= num[127];
          div_req.start <= 1'b1;
          div_req.num   <= num[127] ? (128'd0 - num) : num;
          div_req.den   <= den_d;
          div_req.frac  <= wlf_pkg::FRAC_W'(16);
          div_req.cap   <= num[127] ? 64'h8000_0000 : 64'h7FFF_FFFF;
          state         <= (state == S_ASTART) ? S_AWAIT : S_BWAIT;
        end
        S_AWAIT: begin
          if (div_rsp.done) begin
            fit_a         <= num_neg ? (32'd0 - div_rsp.quo[31:0]) : div_rsp.quo[31:0];
            mul_req.start <= 1'b1;
            mul_req.a     <= mag64(sum_weight);
            mul_req.b     <= mag64(sum_weighted_xy);
            state         <= S_N3;
          end
        end
        S_N3: begin
          if (mul_rsp.done) begin
            term          <= (sum_weight[63] ^ sum_weighted_xy[63]) ? sprod : mul_rsp.prod;
            mul_req.start <= 1'b1;
            mul_req.a     <= mag64(sum_weighted_x);
            mul_req.b     <= mag64(sum_weighted_y);
            state         <= S_N4;
          end
        end
        S_N4: begin
          if (mul_rsp.done) begin
            num   <= (sum_weighted_x[63] ^ sum_weighted_y[63]) ? (term + mul_rsp.prod)
                                                               : (term - mul_rsp.prod);
            state <= S_BSTART;
          end
        end
        S_BWAIT: begin
          if (div_rsp.done) begin
            fit_b         <= num_neg ? (32'd0 - div_rsp.quo[31:0]) : div_rsp.quo[31:0];
            div_req.start <= 1'b1;
            div_req.num   <= {64'b0, sum_weighted_xx};
            div_req.den   <= den_d;
            div_req.frac  <= wlf_pkg::FRAC_W'(48);
            div_req.cap   <= '1;
            state         <= S_EADIV;
          end
        end
        S_EADIV: begin
          if (div_rsp.done) begin
            sqrt_req.start <= 1'b1;
            sqrt_req.val   <= div_rsp.quo;
            state          <= S_EASQ;
          end
        end
        S_EASQ: begin
          if (sqrt_rsp.done) begin
            fit_ea        <= sqrt_rsp.root;
            div_req.start <= 1'b1;
            div_req.num   <= {64'b0, sum_weight};
            div_req.den   <= den_d;
            div_req.frac  <= wlf_pkg::FRAC_W'(48);
            div_req.cap   <= '1;
            state         <= S_EBDIV;
          end
        end
        S_EBDIV: begin
          if (div_rsp.done) begin
            sqrt_req.start <= 1'b1;
            sqrt_req.val   <= div_rsp.quo;
            state          <= S_EBSQ;
          end
        end
        S_EBSQ: begin
          if (sqrt_rsp.done) begin
            fit_eb <= sqrt_rsp.root;
            idx    <= '0;
            chi    <= '0;
            state  <= S_CRD;
          end
        end
        // Chi-square walk: read a stored point, the data arrives next cycle.
        S_CRD: begin
          state <= (idx >= point_count) ? S_EMIT : S_CDATA;
        end
        S_CDATA: begin
          idx <= idx + CW'(1);
          if (rd_sig == 16'd0) begin
            state <= S_CRD;
          end else begin
            bx      <= fit_b * rd_x;
            ya      <= {{16{rd_y[31]}}, rd_y, 16'b0} - {{16{fit_a[31]}}, fit_a, 16'b0};
            chi_den <= {32'(rd_sig) * 32'(rd_sig), 32'b0};
            state   <= S_CRES;
          end
        end
        S_CRES: begin
          mul_req.start <= 1'b1;
          mul_req.a     <= mag64(resid);
          mul_req.b     <= mag64(resid);
          state         <= S_CMUL;
        end
        S_CMUL: begin
          if (mul_rsp.done) begin
            div_req.start <= 1'b1;
            div_req.num   <= mul_rsp.prod;
            div_req.den   <= {64'b0, chi_den};
            div_req.frac  <= '0;
            div_req.cap   <= 64'hFFFF_FFFF;
            state         <= S_CDIV;
          end
        end
        S_CDIV: begin
          if (div_rsp.done) begin
            chi   <= chi_sum[32] ? 32'hFFFF_FFFF : chi_sum[31:0];
            state <= S_CRD;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid       <= 1'b1;
            points_used     <= 13'(point_count);
            fit_status      <= status;
            intercept       <= (status == wlf_pkg::ST_OK) ? fit_a : '0;
            slope           <= (status == wlf_pkg::ST_OK) ? fit_b : '0;
            intercept_error <= (status == wlf_pkg::ST_OK) ? fit_ea : '0;
            slope_error     <= (status == wlf_pkg::ST_OK) ? fit_eb : '0;
            chi_square      <= (status == wlf_pkg::ST_OK) ? chi : '0;
            point_count     <= '0;
            error_flags     <= wlf_pkg::ST_OK;
            sum_weight      <= '0;
            sum_weighted_x  <= '0;
            sum_weighted_y  <= '0;
            sum_weighted_xy <= '0;
            sum_weighted_xx <= '0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The count never passes the store depth.
  `WLF_ASSERT_SAME(a_count_range, 1'b1, point_count <= CW'(wlf_pkg::MAX_POINTS), "point count overran")
  // A last point always starts the fit.
  `WLF_ASSERT_NEXT(a_last_starts_fit, in_acc && last_point, state != S_IDLE, "last point ignored")
  // Loading a result clears the set.
  `WLF_ASSERT_NEXT(a_emit_clears, emit_go, out_valid && (point_count == '0), "set not cleared")
  // A failed fit carries zero results.
  `WLF_ASSERT_SAME(a_fail_zero, out_valid && (fit_status != wlf_pkg::ST_OK), (intercept == '0) && (slope == '0) && (chi_square == '0), "failed fit has data")

endmodule

@@ src/wlf_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module wlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read first: the registered read data holds the old word when that address is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/wlf_mul.sv @@
// Multi-cycle 64 x 64 unsigned multiplier built from one 32 x 32 product per cycle.
// Depends on wlf_pkg.
module wlf_mul (
  input  logic              clk,
  input  logic              rst,
  input  wlf_pkg::mul_req_t req,
  output wlf_pkg::mul_rsp_t rsp
);

  logic [63:0]  areg;
  logic [63:0]  breg;
  logic [2:0]   cnt;
  logic [1:0]   sh;
  logic [63:0]  pp;
  logic [127:0] acc;
  logic         busy;
  logic         done;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [1:0]   sh_now;
  logic [127:0] pp_shifted;

  // Partial product selection for the current step.
  always_comb begin
    a_half = cnt[1] ? areg[63:32] : areg[31:0];
    b_half = cnt[0] ? breg[63:32] : breg[31:0];
    sh_now = {1'b0, cnt[1]} + {1'b0, cnt[0]};
    unique case (sh)
      2'd1:    pp_shifted = {32'b0, pp, 32'b0};
      2'd2:    pp_shifted = {pp, 64'b0};
      default: pp_shifted = {64'b0, pp};
    endcase
  end

  // One registered product per cycle, accumulated the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        areg <= req.a;
        breg <= req.b;
        cnt  <= 3'd0;
        acc  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          pp <= a_half * b_half;
          sh <= sh_now;
        end
        if (cnt != 3'd0) begin
          acc <= acc + pp_shifted;
        end
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

@@ src/wlf_div.sv @@
// Restoring divider, one quotient bit per cycle, with fraction bits and a saturation cap.
// Depends on wlf_pkg.
module wlf_div (
  input  logic              clk,
  input  logic              rst,
  input  wlf_pkg::div_req_t req,
  output wlf_pkg::div_rsp_t rsp
);

  localparam logic [wlf_pkg::STEP_W-1:0] STEP_W_127 = wlf_pkg::STEP_W'(127);

  logic                       busy;
  logic                       trivial;
  logic [127:0]               nreg;
  logic [127:0]               rem;
  logic [127:0]               den;
  logic [63:0]                q;
  logic [63:0]                cap;
  logic [wlf_pkg::STEP_W-1:0] step;
  logic [wlf_pkg::STEP_W-1:0] last_step;
  logic                       done;
  logic [63:0]                quo;
  logic [127:0]               rem_sh;
  logic                       ge;
  logic [127:0]               rem_new;
  logic [63:0]                cap_lim;
  logic                       over;
  logic [63:0]                q_new;

  // One restoring step: shift in the next numerator bit and compare.
  always_comb begin
    rem_sh  = {rem[126:0], nreg[127]};
    ge      = (rem_sh >= den);
    rem_new = ge ? (rem_sh - den) : rem_sh;
    cap_lim = (cap - {63'b0, ge}) >> 1;
    over    = (q > cap_lim);
    q_new   = {q[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        nreg      <= req.num;
        den       <= req.den;
        cap       <= req.cap;
        rem       <= '0;
        q         <= '0;
        step      <= '0;
        last_step <= STEP_W_127 + wlf_pkg::STEP_W'(req.frac);
        trivial   <= (req.den == '0) || req.den[127];
        busy      <= 1'b1;
      end else if (busy) begin
        if (trivial) begin
          quo  <= cap;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          rem  <= rem_new;
          nreg <= {nreg[126:0], 1'b0};
          q    <= q_new;
          step <= step + 1'b1;
          if (over) begin
            quo  <= cap;
            done <= 1'b1;
            busy <= 1'b0;
          end else if (step == last_step) begin
            quo  <= q_new;
            done <= 1'b1;
            busy <= 1'b0;
          end
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

@@ src/wlf_sqrt.sv @@
// Iterative 64-bit integer square root, one result bit per cycle.
// Depends on wlf_pkg.
module wlf_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  wlf_pkg::sqrt_req_t req,
  output wlf_pkg::sqrt_rsp_t rsp
);

  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [31:0] root;
  logic [63:0] trial;
  logic        take;
  logic [63:0] r_new;

  // Digit-by-digit step.
  always_comb begin
    trial = r + bitv;
    take  = (v >= trial);
    r_new = take ? ((r >> 1) + bitv) : (r >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        v    <= req.val;
        r    <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (take) begin
          v <= v - trial;
        end
        r    <= r_new;
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          root <= r_new[31:0];
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

@@ tb/sv/weighted_line_fit_unit_tb.sv @@
// Self-checking testbench for the weighted least-squares line fit unit.
// Depends on wlf_pkg and weighted_line_fit_unit; predicts each fit result and
// compares it field by field with what the block returns.
module weighted_line_fit_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] sigma;
    logic        last;
    logic        drain;
  } point_t;

  typedef struct {
    logic [31:0] intercept;
    logic [31:0] slope;
    logic [31:0] intercept_error;
    logic [31:0] slope_error;
    logic [31:0] chi_square;
    logic [12:0] points_used;
    logic [1:0]  fit_status;
  } fit_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] x_value;
  logic [31:0] y_value;
  logic [15:0] sigma_value;
  logic        last_point;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] intercept;
  logic [31:0] slope;
  logic [31:0] intercept_error;
  logic [31:0] slope_error;
  logic [31:0] chi_square;
  logic [12:0] points_used;
  logic [1:0]  fit_status;

  point_t pending_points[$];
  fit_t   expected_fits[$];
  int     errors;
  int     accepted;
  int     cycles;
  int     send_idle_pct;
  int     recv_idle_pct;

  // Running state of the current data set.
  logic [31:0]        set_x[wlf_pkg::MAX_POINTS];
  logic [31:0]        set_y[wlf_pkg::MAX_POINTS];
  logic [15:0]        set_sigma[wlf_pkg::MAX_POINTS];
  int                 set_count;
  logic [63:0]        sum_w;
  logic signed [63:0] sum_wx, sum_wy, sum_wxy, sum_wxx;
  logic [1:0]         set_flags;

  weighted_line_fit_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] sat_sum(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] t;
    t = a + b;
    if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (t < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return t[63:0];
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Truncating quotient n * 2^frac / d, clamped to cap.
  function automatic logic [63:0] quot_capped(logic [127:0] n, logic [127:0] d, int frac,
                                              logic [63:0] cap);
    logic [191:0] q;
    if (d == 0 || d[127]) return cap;
    q = ({64'b0, n} << frac) / {64'b0, d};
    return (q > {128'b0, cap}) ? cap : q[63:0];
  endfunction

  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [63:0] r, t;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= v) r = t;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] ratio_q16(logic [127:0] n, logic [127:0] d);
    logic        neg;
    logic [63:0] q;
    neg = n[127];
    q = quot_capped(neg ? -n : n, d, 16, neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic logic [127:0] prod_s(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [127:0] ea, eb;
    ea = a;
    eb = b;
    return ea * eb;
  endfunction

  function automatic void clear_set();
    set_count = 0;
    sum_w = 0;
    sum_wx = 0;
    sum_wy = 0;
    sum_wxy = 0;
    sum_wxx = 0;
    set_flags = wlf_pkg::ST_OK;
  endfunction

  // Fold one point into the set and, on the last point, compute the fit.
  function automatic void predict_point(point_t p);
    logic signed [63:0] xs, ys, tx, ty, txx, txy, ai, bi, xi, yi, res;
    logic [63:0]        mx, my, w, wx, s, chi;
    logic [127:0]       pr, pp, qq, d, nn;
    fit_t               f;
    if (set_count >= wlf_pkg::MAX_POINTS) begin
      set_flags = wlf_pkg::ST_OVERFLOW;
    end else begin
      xs = $signed(p.x);
      ys = $signed(p.y);
      mx = mag(xs);
      my = mag(ys);
      s = p.sigma;
      set_x[set_count] = p.x;
      set_y[set_count] = p.y;
      set_sigma[set_count] = p.sigma;
      set_count++;
      w = 0;
      if (s == 0) begin
        if (set_flags < wlf_pkg::ST_ZERO_SIGMA) set_flags = wlf_pkg::ST_ZERO_SIGMA;
      end else begin
        w = (64'd1 << 32) / (s * s);
      end
      wx = w * mx;
      tx = wx >> 16;
      if (xs < 0) tx = -tx;
      ty = (w * my) >> 16;
      if (ys < 0) ty = -ty;
      pr = {64'b0, wx} * {64'b0, mx};
      txx = pr[95:32];
      pr = {64'b0, wx} * {64'b0, my};
      txy = pr[95:32];
      if ((xs < 0) != (ys < 0)) txy = -txy;
      sum_w += w;
      sum_wx = sat_sum(sum_wx, tx);
      sum_wy = sat_sum(sum_wy, ty);
      sum_wxx = sat_sum(sum_wxx, txx);
      sum_wxy = sat_sum(sum_wxy, txy);
    end
    if (!p.last) return;

    f = '{default: '0};
    f.points_used = set_count[12:0];
    f.fit_status = set_flags;
    if (f.fit_status == wlf_pkg::ST_OK && set_count < 2) f.fit_status = wlf_pkg::ST_ZERO_DEN;
    if (f.fit_status == wlf_pkg::ST_OK) begin
      pp = {64'b0, sum_w} * {64'b0, sum_wxx};
      qq = {64'b0, mag(sum_wx)} * {64'b0, mag(sum_wx)};
      if (pp <= qq) begin
        f.fit_status = wlf_pkg::ST_ZERO_DEN;
      end else begin
        d = pp - qq;
        nn = prod_s(sum_wxx, sum_wy) - prod_s(sum_wx, sum_wxy);
        f.intercept = ratio_q16(nn, d);
        nn = prod_s($signed(sum_w), sum_wxy) - prod_s(sum_wx, sum_wy);
        f.slope = ratio_q16(nn, d);
        f.intercept_error = floor_root(quot_capped({64'b0, sum_wxx}, d, 48, '1));
        f.slope_error = floor_root(quot_capped({64'b0, sum_w}, d, 48, '1));
        // Chi-square walk over the stored points, using the emitted codes.
        ai = $signed(f.intercept);
        bi = $signed(f.slope);
        chi = 0;
        for (int i = 0; i < set_count; i++) begin
          if (set_sigma[i] == 0) continue;
          xi = $signed(set_x[i]);
          yi = $signed(set_y[i]);
          s = set_sigma[i];
          res = yi * 65536 - (ai * 65536 + bi * xi);
          pr = {64'b0, mag(res)} * {64'b0, mag(res)};
          chi += quot_capped(pr, {64'b0, (s * s) << 32}, 0, 64'hFFFF_FFFF);
          if (chi > 64'hFFFF_FFFF) chi = 64'hFFFF_FFFF;
        end
        f.chi_square = chi[31:0];
      end
    end
    expected_fits.push_back(f);
    clear_set();
  endfunction

  // Point driver: predicts each accepted transaction, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      accepted <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_point('{x_value, y_value, sigma_value, last_point, 1'b0});
        accepted <= accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_points.size() == 0 || $urandom_range(99) < send_idle_pct
            || (pending_points[0].drain && expected_fits.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          point_t p;
          p = pending_points.pop_front();
          in_valid <= 1'b1;
          x_value <= p.x;
          y_value <= p.y;
          sigma_value <= p.sigma;
          last_point <= p.last;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      errors <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_fits.size() == 0) begin
          $display("%0t: unexpected fit result, intercept %h", $time, intercept);
          errors <= errors + 1;
        end else begin
          fit_t e;
          e = expected_fits.pop_front();
          if (e.intercept !== intercept || e.slope !== slope
              || e.intercept_error !== intercept_error || e.slope_error !== slope_error
              || e.chi_square !== chi_square || e.points_used !== points_used
              || e.fit_status !== fit_status) begin
            $display("%0t: fit mismatch: expected a=%h b=%h ea=%h eb=%h chi=%h n=%0d st=%0d",
                     $time, e.intercept, e.slope, e.intercept_error, e.slope_error,
                     e.chi_square, e.points_used, e.fit_status);
            $display("%0t:                  actual a=%h b=%h ea=%h eb=%h chi=%h n=%0d st=%0d",
                     $time, intercept, slope, intercept_error, slope_error,
                     chi_square, points_used, fit_status);
            errors <= errors + 1;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 6000000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void queue_point(logic [31:0] x, logic [31:0] y, logic [15:0] s,
                                      logic last, logic drain = 1'b0);
    pending_points.push_back('{x, y, s, last, drain});
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [15:0] rand_sigma();
    case ($urandom_range(19))
      0: return 16'd0;
      1: return 16'($urandom);
      2: return 16'($urandom_range(1, 15));
      default: return 16'($urandom_range(64, 1024));
    endcase
  endfunction

  initial begin
    int n;
    logic [31:0] slope_code, base;
    cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    x_value = '0;
    y_value = '0;
    sigma_value = '0;
    last_point = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 86;
    clear_set();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed sets: a clean line, field extremes, a lone point, equal x,
    // zero sigma.
    queue_point(32'h0001_0000, 32'h0001_0000, 16'h0100, 1'b0);
    queue_point(32'h0002_0000, 32'h0003_0000, 16'h0100, 1'b0);
    queue_point(32'h0003_0000, 32'h0004_8000, 16'h0100, 1'b1);
    queue_point(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 16'h0001, 1'b0);
    queue_point(32'h0000_0000, 32'hFFFF_FFFF, 16'h0001, 1'b1);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 16'h0001, 1'b0);
    queue_point(32'h8000_0000, 32'h7FFF_FFFF, 16'h0001, 1'b1);
    queue_point(32'h0004_0000, 32'h0002_0000, 16'h0200, 1'b1);
    queue_point(32'h0005_0000, 32'h0001_0000, 16'h0100, 1'b0);
    queue_point(32'h0005_0000, 32'h0007_0000, 16'h0080, 1'b1);
    queue_point(32'h0001_0000, 32'h0001_0000, 16'h0100, 1'b0);
    queue_point(32'h0002_0000, 32'h0002_0000, 16'h0000, 1'b0);
    queue_point(32'h0003_0000, 32'h0003_0000, 16'h0100, 1'b1);
    queue_point(32'hFFFF_0000, 32'h0000_0001, 16'h00FF, 1'b0, 1'b1);
    queue_point(32'h0001_0000, 32'hFFFF_FFFF, 16'h0101, 1'b1);

    // Random sets, mostly near a line with noise so the fit is well formed.
    n = 0;
    while (n < 1430) begin
      int size;
      size = ($urandom_range(15) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 8);
      slope_code = 32'($signed($urandom_range(1 << 19)) - (1 << 18));
      base = 32'($signed($urandom_range(1 << 21)) - (1 << 20));
      for (int k = 0; k < size; k++) begin
        logic [31:0] x, y;
        x = rand_coord();
        if ($urandom_range(3) == 0) begin
          y = $urandom;
        end else begin
          y = base + 32'(($signed(64'($signed(slope_code))) * $signed(64'($signed(x)))) >>> 16)
              + 32'($urandom_range(1 << 12)) - (1 << 11);
        end
        queue_point(x, y, rand_sigma(), k == size - 1);
      end
      n += size;
      if (n > 480 && send_idle_pct == 6) begin
        wait (pending_points.size() == 0);
        send_idle_pct = 86;
        recv_idle_pct = 6;
      end else if (n > 960 && send_idle_pct == 86) begin
        wait (pending_points.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    wait (pending_points.size() == 0 && !in_valid);
    wait (expected_fits.size() == 0);
    repeat (3000) @(posedge clk);
    if (errors == 0 && expected_fits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
